>>> hdl/qte_pkg.sv
// shared constants for the quaternion to euler angle pipeline
// arctangent table, angle limits and square root sizes; no dependencies
`default_nettype none
package qte_pkg;
	localparam int ZW        = 35;  // q30 angle accumulator width
	localparam int TAB_LEN   = 24;
	localparam int SQ_W      = 62;  // square root radicand / remainder width
	localparam int ISQ_STEPS = 31;  // one result bit per stage
	localparam int ROOT_W    = 31;
	localparam int OUT_W     = 18;  // q13 angle after the rounding shift

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [OUT_W-1:0] ANGLE_MAX   = 18'sd25736;
	localparam logic signed [OUT_W-1:0] HALF_PI_OUT = 18'sd12868;

	localparam logic signed [ZW-1:0] ATAN_Q30 [0:TAB_LEN-1] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043836, 35'sd133525158,
		35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
		35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
		35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
		35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
		35'sd1023,      35'sd511,       35'sd255,       35'sd127
	};
endpackage
`default_nettype wire

>>> hdl/qte_if.sv
// valid/ready channels for quaternion items and euler angle items
// no dependencies
`default_nettype none
interface qte_quat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               gimbal_lock;
	modport source(output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		output ready);
endinterface
`default_nettype wire

>>> hdl/qte_cordic.sv
// pipelined vectoring cordic, atan2(y, x) in q30 radians
// one quadrant stage plus one stage per rotation; uses qte_pkg
`default_nettype none
module qte_cordic import qte_pkg::*; #(
	parameter int W  = 38,
	parameter int NS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [W-1:0]  y_i,
	input  wire logic signed [W-1:0]  x_i,
	output logic signed [ZW-1:0]      z_o
);
	logic signed [W-1:0]  x_s    [0:NS];
	logic signed [W-1:0]  y_s    [0:NS];
	logic signed [ZW-1:0] z_s    [0:NS];
	logic                 zero_s [0:NS];

	// fold the left half plane by a half turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_i == '0) && (y_i == '0);
			if (x_i < 0) begin
				x_s[0] <= -x_i;
				y_s[0] <= -y_i;
				z_s[0] <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0] <= x_i;
				y_s[0] <= y_i;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_Q30[i];
				end
			end
		end
	end

	assign z_o = zero_s[NS] ? '0 : z_s[NS];
endmodule
`default_nettype wire

>>> hdl/qte_isqrt.sv
// pipelined integer square root, one result bit per stage
// radicand at most 2^60; uses qte_pkg
`default_nettype none
module qte_isqrt import qte_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SQ_W-2:0]   v_i,
	output logic [ROOT_W-1:0]      root_o
);
	logic [SQ_W-1:0] v_s [0:ISQ_STEPS];
	logic [SQ_W-1:0] r_s [0:ISQ_STEPS];

	assign v_s[0] = {1'b0, v_i};
	assign r_s[0] = '0;

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_bit
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[k] >= r_s[k] + BIT) begin
					v_s[k+1] <= v_s[k] - (r_s[k] + BIT);
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root_o = r_s[ISQ_STEPS][ROOT_W-1:0];
endmodule
`default_nettype wire

>>> hdl/quaternion_to_euler_angles.sv
// quaternion to zyx euler angles (roll, pitch, yaw), fully pipelined
// throughput: one item per cycle; the isqrt (31 stages) and cordic set the depth
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears the valid bits only; uses qte_pkg, qte_if, qte_cordic, qte_isqrt
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int CORDIC_STEPS   = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	qte_quat_if.sink     quat,
	qte_euler_if.source  euler
);
	localparam int F2  = 2 * QUAT_FRAC_BITS;
	localparam int NS  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int CL  = NS + 1;                 // cordic latency
	// raw sums in q(2F), and q30 cordic operands with headroom for gain
	localparam int RW  = ((F2 > 32) ? F2 : 32) + 3;
	localparam int SHR = (F2 >= 30) ? F2 - 30 : 0;
	localparam int SHL = (F2 < 30) ? 30 - F2 : 0;
	localparam int W   = 36 + SHL;
	localparam int BW  = RW + W;
	localparam int DLY = 1 + ISQ_STEPS;          // multiply plus isqrt
	localparam int L   = 2 + DLY + CL + 1;       // full latency

	logic en;
	logic vld_q [1:L];

	// the pipeline moves whenever the output register is free or being taken
	assign en         = !vld_q[L] || euler.ready;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= L; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= quat.valid;
			for (int i = 2; i <= L; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: the nine component products
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat.quat_w * quat.quat_x;
			yz_s1 <= quat.quat_y * quat.quat_z;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			wy_s1 <= quat.quat_w * quat.quat_y;
			zx_s1 <= quat.quat_z * quat.quat_x;
			wz_s1 <= quat.quat_w * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
		end
	end

	// stage 2: sine and cosine terms, brought to q30
	logic signed [RW-1:0] one_c;
	logic signed [RW-1:0] e_wx, e_yz, e_xx, e_yy, e_wy, e_zx, e_wz, e_xy, e_zz;
	logic signed [RW-1:0] sr_raw, cr_raw, sp_raw, sy_raw, cy_raw;
	logic signed [BW-1:0] sr_b, cr_b, sp_b, sy_b, cy_b;
	logic signed [BW-1:0] sr_w, cr_w, sp_w, sy_w, cy_w;
	logic signed [W-1:0]  sn_abs;
	logic [ROOT_W-1:0]    a_c;

	always_comb begin
		one_c  = RW'(1) <<< F2;
		e_wx = wx_s1; e_yz = yz_s1; e_xx = xx_s1; e_yy = yy_s1; e_wy = wy_s1;
		e_zx = zx_s1; e_wz = wz_s1; e_xy = xy_s1; e_zz = zz_s1;
		sr_raw = (e_wx + e_yz) <<< 1;
		cr_raw = one_c - ((e_xx + e_yy) <<< 1);
		sp_raw = (e_wy - e_zx) <<< 1;
		sy_raw = (e_wz + e_xy) <<< 1;
		cy_raw = one_c - ((e_yy + e_zz) <<< 1);
		sr_b = sr_raw; cr_b = cr_raw; sp_b = sp_raw; sy_b = sy_raw; cy_b = cy_raw;
		// floor shift right or exact shift left, one of them is zero
		sr_w = (sr_b >>> SHR) <<< SHL;
		cr_w = (cr_b >>> SHR) <<< SHL;
		sp_w = (sp_b >>> SHR) <<< SHL;
		sy_w = (sy_b >>> SHR) <<< SHL;
		cy_w = (cy_b >>> SHR) <<< SHL;
		sn_abs = (sp_w < 0) ? -sp_w[W-1:0] : sp_w[W-1:0];
		// clamp |s| to one in q30
		if (sn_abs > W'(1 << 30)) a_c = ROOT_W'(1 << 30);
		else a_c = sn_abs[ROOT_W-1:0];
	end

	logic signed [W-1:0] sr_s2, cr_s2, sn_s2, sy_s2, cy_s2;
	logic [ROOT_W-1:0]   a_s2;
	logic                sat_s2, spos_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2   <= sr_w[W-1:0];
			cr_s2   <= cr_w[W-1:0];
			sn_s2   <= sp_w[W-1:0];
			sy_s2   <= sy_w[W-1:0];
			cy_s2   <= cy_w[W-1:0];
			a_s2    <= a_c;
			sat_s2  <= (sp_raw >= one_c) || (sp_raw <= -one_c);
			spos_s2 <= sp_raw > 0;
		end
	end

	// stage 3: radicand (1 - s)(1 + s) in q60
	logic [SQ_W-2:0] rad_s3;
	logic [ROOT_W:0] lo_c, hi_c;

	assign lo_c = (ROOT_W+1)'(1 << 30) - {1'b0, a_s2};
	assign hi_c = (ROOT_W+1)'(1 << 30) + {1'b0, a_s2};

	always_ff @(posedge clk) begin
		if (en) rad_s3 <= (SQ_W-1)'(lo_c) * (SQ_W-1)'(hi_c);
	end

	// isqrt, then the pitch cordic on (s, sqrt(1 - s^2))
	logic [ROOT_W-1:0] root;

	qte_isqrt u_isqrt (
		.clk    (clk),
		.en     (en),
		.v_i    (rad_s3),
		.root_o (root)
	);

	// sine term waits for the root
	logic signed [W-1:0] sn_d [1:DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			sn_d[1] <= sn_s2;
			for (int i = 2; i <= DLY; i++) sn_d[i] <= sn_d[i-1];
		end
	end

	logic signed [ZW-1:0] pz, rz, yz;
	logic signed [W-1:0]  cos_p;

	assign cos_p = {{(W - ROOT_W){1'b0}}, root};

	qte_cordic #(.W(W), .NS(NS)) u_pitch (
		.clk (clk), .en (en), .y_i (sn_d[DLY]), .x_i (cos_p), .z_o (pz)
	);

	// roll and yaw run early and are delayed to meet pitch
	qte_cordic #(.W(W), .NS(NS)) u_roll (
		.clk (clk), .en (en), .y_i (sr_s2), .x_i (cr_s2), .z_o (rz)
	);

	qte_cordic #(.W(W), .NS(NS)) u_yaw (
		.clk (clk), .en (en), .y_i (sy_s2), .x_i (cy_s2), .z_o (yz)
	);

	logic signed [ZW-1:0] rz_d [1:DLY];
	logic signed [ZW-1:0] yz_d [1:DLY];
	logic                 sat_d  [1:DLY+CL];
	logic                 spos_d [1:DLY+CL];

	always_ff @(posedge clk) begin
		if (en) begin
			rz_d[1]   <= rz;
			yz_d[1]   <= yz;
			sat_d[1]  <= sat_s2;
			spos_d[1] <= spos_s2;
			for (int i = 2; i <= DLY; i++) begin
				rz_d[i] <= rz_d[i-1];
				yz_d[i] <= yz_d[i-1];
			end
			for (int i = 2; i <= DLY + CL; i++) begin
				sat_d[i]  <= sat_d[i-1];
				spos_d[i] <= spos_d[i-1];
			end
		end
	end

	// q30 to q3.13, round half up, then clamp
	function automatic logic signed [OUT_W-1:0] to_out(
		input logic signed [ZW-1:0] z,
		input logic signed [OUT_W-1:0] lim
	);
		logic signed [ZW-1:0]    zr;
		logic signed [OUT_W-1:0] r;
		zr = (z + ZW'(1 << 16)) >>> 17;
		r  = zr[OUT_W-1:0];
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	logic signed [OUT_W-1:0] roll_c, pitch_c, yaw_c;

	always_comb begin
		roll_c = to_out(rz_d[DLY], ANGLE_MAX);
		yaw_c  = to_out(yz_d[DLY], ANGLE_MAX);
		if (sat_d[DLY+CL]) pitch_c = spos_d[DLY+CL] ? HALF_PI_OUT : -HALF_PI_OUT;
		else pitch_c = to_out(pz, HALF_PI_OUT);
	end

	// output register, last pipeline stage
	logic signed [15:0] roll_s, yaw_s;
	logic signed [14:0] pitch_s;
	logic               lock_s;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s  <= roll_c[15:0];
			pitch_s <= pitch_c[14:0];
			yaw_s   <= yaw_c[15:0];
			lock_s  <= sat_d[DLY+CL];
		end
	end

	assign euler.valid       = vld_q[L];
	assign euler.roll_angle  = roll_s;
	assign euler.pitch_angle = pitch_s;
	assign euler.yaw_angle   = yaw_s;
	assign euler.gimbal_lock = lock_s;
endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for quaternion_to_euler_angles
// random and directed quaternion items checked against an integer zyx euler predictor
// depends on qte_pkg, qte_if and the block itself
`default_nettype none
module testbench import qte_pkg::*; ();

	localparam int STEPS      = 16;
	localparam int FRAC       = 14;
	localparam int RAND_ITEMS = 1900;
	localparam int LIMIT      = 400000;
	localparam int TAIL       = 80;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               lock;
	} euler_t;

	// one stimulus row: quaternion plus an optional typed-in expectation
	typedef struct {
		logic signed [15:0] x, y, z, w;
		bit                 fixed;
		euler_t             want;
	} quat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_quat_if  quat();
	qte_euler_if euler();

	quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS), .QUAT_FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n), .quat(quat.sink), .euler(euler.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	euler_t angles_due[$];
	int     errors = 0;
	int     cycles = 0;
	bit     feed_done = 1'b0;

	// floor shift that never shifts a negative number
	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint as_q30(longint v);
		if (2 * FRAC >= 30)
			return floor_shift(v, 2 * FRAC - 30);
		return v * (64'sd1 <<< (30 - 2 * FRAC));
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// vectoring cordic, q30 in and out
	function automatic longint vector_angle(longint y, longint x);
		longint ang, dx, dy;
		int     n;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
			x = -x;
			y = -y;
		end
		n = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; ang += longint'(ATAN_Q30[i]);
			end else begin
				x -= dx; y += dy; ang -= longint'(ATAN_Q30[i]);
			end
		end
		return ang;
	endfunction

	function automatic longint round_angle(longint a, longint lim);
		longint r;
		r = floor_shift(a + (64'sd1 <<< 16), 17);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic euler_t predict_angles(logic signed [15:0] x, y, z, w);
		longint qx, qy, qz, qw, one, sr, cr, sp, sy, cy, sn, mag, unit, c;
		euler_t e;
		qx = x; qy = y; qz = z; qw = w;
		one  = 64'sd1 <<< (2 * FRAC);
		unit = 64'sd1 <<< 30;
		sr = 2 * (qw * qx + qy * qz);
		cr = one - 2 * (qx * qx + qy * qy);
		sp = 2 * (qw * qy - qz * qx);
		sy = 2 * (qw * qz + qx * qy);
		cy = one - 2 * (qy * qy + qz * qz);
		e.roll = 16'(round_angle(vector_angle(as_q30(sr), as_q30(cr)), ANGLE_MAX));
		e.yaw  = 16'(round_angle(vector_angle(as_q30(sy), as_q30(cy)), ANGLE_MAX));
		if (sp >= one || sp <= -one) begin
			// gimbal lock: pitch pinned to +-pi/2
			e.pitch = (sp > 0) ? 15'(HALF_PI_OUT) : -15'(HALF_PI_OUT);
			e.lock  = 1'b1;
		end else begin
			sn  = as_q30(sp);
			mag = (sn < 0) ? -sn : sn;
			if (mag > unit) mag = unit;
			c = int_sqrt(longint'(unit - mag) * longint'(unit + mag));
			e.pitch = 15'(round_angle(vector_angle(sn, c), HALF_PI_OUT));
			e.lock  = 1'b0;
		end
		return e;
	endfunction

	// directed rows: extremes, identity, axis turns, gimbal lock, zero vector
	quat_row_t directed[$];

	function automatic quat_row_t mk(int x, y, z, w, bit fixed = 0,
		int r = 0, p = 0, yw = 0, l = 0);
		quat_row_t q;
		q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
		q.fixed = fixed;
		q.want.roll = 16'(r); q.want.pitch = 15'(p);
		q.want.yaw = 16'(yw); q.want.lock = l[0];
		return q;
	endfunction

	initial begin
		directed.push_back(mk(0, 0, 0, 16384, 1, 0, 0, 0, 0));      // identity
		directed.push_back(mk(0, 8192, 0, 16384, 1, 0, 12868, 0, 1));   // pitch +pi/2 lock
		directed.push_back(mk(0, -8192, 0, 16384, 1, 0, -12868, 0, 1));
		directed.push_back(mk(0, 16384, 0, 16384, 1, 25736, 12868, 25736, 1));
		directed.push_back(mk(0, 0, 0, 0));                           // zero vector
		directed.push_back(mk(16384, 0, 0, 0));                       // roll pi
		directed.push_back(mk(-16384, 0, 0, 0));
		directed.push_back(mk(0, 0, 16384, 0));                       // yaw pi
		directed.push_back(mk(0, 0, -16384, 0));
		directed.push_back(mk(0, 16384, 0, 0));
		directed.push_back(mk(11585, 0, 0, 11585));                   // 90 degree turns
		directed.push_back(mk(-11585, 0, 0, 11585));
		directed.push_back(mk(0, 0, 11585, 11585));
		directed.push_back(mk(0, 0, -11585, 11585));
		directed.push_back(mk(8192, 8192, 8192, 8192));
		directed.push_back(mk(-32768, -32768, -32768, -32768));       // out of range
		directed.push_back(mk(32767, 32767, 32767, 32767));
		directed.push_back(mk(-32768, 32767, -32768, 32767));
		directed.push_back(mk(32767, -32768, 32767, -32768));
		directed.push_back(mk(16384, 16384, 16384, 16384));
		directed.push_back(mk(-16384, 16384, -16384, 16384));
		directed.push_back(mk(1, -1, 1, -1));
	end

	// random quaternion: mostly near-unit rotations, some raw noise, some near gimbal lock
	function automatic quat_row_t rand_row();
		quat_row_t q;
		int a, b, c, d;
		real n;
		if ($urandom_range(0, 9) < 7) begin
			a = $urandom_range(0, 32768) - 16384;
			b = $urandom_range(0, 32768) - 16384;
			c = $urandom_range(0, 32768) - 16384;
			d = $urandom_range(0, 32768) - 16384;
			n = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c + real'(d) * d);
			if (n < 1.0) n = 1.0;
			q = mk($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
				$rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
		end else if ($urandom_range(0, 1)) begin
			q = mk(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
		end else begin
			// near gimbal lock: w = y or w = -y
			a = $urandom_range(11570, 11600);
			q = mk($urandom_range(0, 20) - 10, $urandom_range(0, 1) ? a : -a,
				$urandom_range(0, 20) - 10, a);
		end
		return q;
	endfunction

	// quaternion source
	initial begin
		quat_row_t row;
		int gap;
		quat.valid  <= 1'b0;
		quat.quat_x <= '0;
		quat.quat_y <= '0;
		quat.quat_z <= '0;
		quat.quat_w <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < directed.size() + RAND_ITEMS; i++) begin
			row = (i < directed.size()) ? directed[i] : rand_row();
			// long stretches without gaps in the middle of the random run
			gap = (i >= 600 && i < 900) ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				quat.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			quat.valid  <= 1'b1;
			quat.quat_x <= row.x;
			quat.quat_y <= row.y;
			quat.quat_z <= row.z;
			quat.quat_w <= row.w;
			@(posedge clk);
			while (!quat.ready) @(posedge clk);
			// item accepted at this edge
			if (row.fixed && row.want != predict_angles(row.x, row.y, row.z, row.w)) begin
				$display("%0t directed row %0d disagrees with predictor", $time, i);
				errors++;
			end
			angles_due.push_back(row.fixed ? row.want
				: predict_angles(row.x, row.y, row.z, row.w));
		end
		quat.valid <= 1'b0;
		feed_done = 1'b1;
	end

	// euler sink: random stalls, with a stall-free stretch
	initial begin
		int stall, got;
		euler.ready <= 1'b0;
		got = 0;
		@(posedge arst_n);
		forever begin
			stall = (got >= 1000 && got < 1300) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				euler.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			euler.ready <= 1'b1;
			@(posedge clk);
			while (!euler.valid) @(posedge clk);
			got++;
		end
	end

	// compare every accepted euler item against the oldest prediction
	always @(posedge clk) begin
		euler_t want;
		if (arst_n && euler.valid && euler.ready) begin
			if (angles_due.size() == 0) begin
				$display("%0t unexpected item roll=%0d pitch=%0d yaw=%0d lock=%0b", $time,
					euler.roll_angle, euler.pitch_angle, euler.yaw_angle, euler.gimbal_lock);
				errors++;
			end else begin
				want = angles_due.pop_front();
				if (euler.roll_angle !== want.roll) begin
					$display("%0t roll expected %0d got %0d", $time, want.roll,
						euler.roll_angle);
					errors++;
				end
				if (euler.pitch_angle !== want.pitch) begin
					$display("%0t pitch expected %0d got %0d", $time, want.pitch,
						euler.pitch_angle);
					errors++;
				end
				if (euler.yaw_angle !== want.yaw) begin
					$display("%0t yaw expected %0d got %0d", $time, want.yaw,
						euler.yaw_angle);
					errors++;
				end
				if (euler.gimbal_lock !== want.lock) begin
					$display("%0t gimbal_lock expected %0b got %0b", $time, want.lock,
						euler.gimbal_lock);
					errors++;
				end
			end
		end
	end

	// end of run: drain, then a short tail for stray items
	initial begin
		wait (feed_done);
		while (angles_due.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("[quaternion_to_euler_angles] OK");
		else
			$display("[quaternion_to_euler_angles] ERROR");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[quaternion_to_euler_angles] ERROR");
			$finish;
		end
	end
endmodule
`default_nettype wire
